// ===== sv/rcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants for the request command parser.
// ----------------------------------------------------------------------------
package rcp_pkg;

   localparam int LINE_W  = 17;
   localparam int NUM_W   = 32;
   localparam int CNT_W   = 31;
   localparam int BYTE_W  = 8;
   localparam int EV_W    = 3;
   localparam int AIDX_W  = 10;
   localparam int PROD_W  = 36;

   localparam logic [LINE_W-1:0] LINE_LIMIT_RESET = 17'd4096;
   localparam logic [LINE_W-1:0] MIN_ARG_LINE     = 17'd3;
   localparam logic [1:0]        SKIP_BYTES       = 2'd2;

   localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

   localparam logic [PROD_W-1:0] POS_LIMIT = 36'h0_7FFF_FFFF;
   localparam logic [PROD_W-1:0] NEG_LIMIT = 36'h0_8000_0000;

   localparam logic [EV_W-1:0] EV_ARG_START = 3'd0;
   localparam logic [EV_W-1:0] EV_ARG_BYTE  = 3'd1;
   localparam logic [EV_W-1:0] EV_CMD_DONE  = 3'd2;
   localparam logic [EV_W-1:0] EV_PREFIX    = 3'd3;
   localparam logic [EV_W-1:0] EV_NUMBER    = 3'd4;
   localparam logic [EV_W-1:0] EV_LONG      = 3'd5;

   typedef enum logic [2:0] {
      PH_HDR,
      PH_ARGHDR,
      PH_DATA,
      PH_SKIP,
      PH_DISCARD
   } phase_type;

   typedef struct packed {
      logic sign;
      logic digit;
      logic stop;
      logic ovf;
   } num_flags_type;

   typedef struct packed {
      logic [EV_W-1:0]   event_res;
      logic [AIDX_W-1:0] arg_index;
      logic [CNT_W-1:0]  arg_length;
      logic [BYTE_W-1:0] data_byte;
      logic              last_of_arg;
   } rsp_type;

endpackage

// ===== sv/resp_command_parser_top.sv =====
// ----------------------------------------------------------------------------
// resp_command_parser_top
// Byte-serial request command parser with registered input and result.
// ----------------------------------------------------------------------------
// Takes one request byte per clock while the result side keeps up and gives at
// most one result word per byte; each byte passes through the input register,
// then its word is loaded into the result register. The parser state advances
// once per byte, so a byte can be taken every clock as long as the result side
// keeps up; a stalled result word holds the input register, and req_ready drops
// while both registers are full and the result word is stalled. line_limit is
// written through csr_wr_en and csr_wr_data and resets to 4096; the user must
// write it only while the block is quiet, which the block does not enforce.
module resp_command_parser_top
   import rcp_pkg::*;
#(
   parameter int MAX_ARGS = 1024
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [EV_W-1:0]   rsp_event_res,
   output logic [AIDX_W-1:0] rsp_arg_index,
   output logic [CNT_W-1:0]  rsp_arg_length,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output logic              rsp_last_of_arg,
   input  logic              csr_wr_en,
   input  logic [LINE_W-1:0] csr_wr_data
);

   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_vld_ff;
   rsp_type           rsp_ff;
   logic [LINE_W-1:0] line_limit_ff;
   logic              advance;
   logic              fire;
   rsp_type           rsp_nxt;

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   rcp_fsm #(
      .MAX_ARGS (MAX_ARGS)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (in_byte_ff),
      .line_limit (line_limit_ff),
      .rsp_fire   (fire),
      .rsp        (rsp_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= LINE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         line_limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && fire) begin
         rsp_ff <= rsp_nxt;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_event_res   = rsp_ff.event_res;
   assign rsp_arg_index   = rsp_ff.arg_index;
   assign rsp_arg_length  = rsp_ff.arg_length;
   assign rsp_data_byte   = rsp_ff.data_byte;
   assign rsp_last_of_arg = rsp_ff.last_of_arg;

endmodule

// ===== sv/rcp_num.sv =====
// ----------------------------------------------------------------------------
// rcp_num
// One decimal digit step of the header number: sign, digits, stop, overflow.
// ----------------------------------------------------------------------------
module rcp_num
   import rcp_pkg::*;
(
   input  logic [BYTE_W-1:0] ch,
   input  logic              first,
   input  logic [NUM_W-1:0]  acc_cur,
   input  num_flags_type     flags_cur,
   output logic [NUM_W-1:0]  acc_nxt,
   output num_flags_type     flags_nxt
);

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] limit;
   logic [BYTE_W-1:0] digit_val;

   assign digit_val = ch - CH_ZERO;
   assign prod  = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
                + {{(PROD_W-BYTE_W){1'b0}}, digit_val};
   assign limit = flags_cur.sign ? NEG_LIMIT : POS_LIMIT;

   always_comb begin
      acc_nxt   = acc_cur;
      flags_nxt = flags_cur;
      if (!flags_cur.stop) begin
         if (first && ch == CH_MINUS) begin
            flags_nxt.sign = 1'b1;
         end else if (ch < CH_ZERO || ch > CH_NINE) begin
            flags_nxt.stop = 1'b1;
         end else begin
            flags_nxt.digit = 1'b1;
            if (!flags_cur.ovf) begin
               if (prod > limit) begin
                  flags_nxt.ovf = 1'b1;
               end else begin
                  acc_nxt = prod[NUM_W-1:0];
               end
            end
         end
      end
   end

endmodule

// ===== sv/rcp_fsm.sv =====
// ----------------------------------------------------------------------------
// rcp_fsm
// Parser state and per-word decode: header lines, payload, trailer skip, long-line discard.
// ----------------------------------------------------------------------------
module rcp_fsm
   import rcp_pkg::*;
#(
   parameter int MAX_ARGS = 1024
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic [LINE_W-1:0] line_limit,
   output logic              rsp_fire,
   output rsp_type           rsp
);

   localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_ARGS - 1);

   phase_type          phase_ff, phase_in;
   logic [LINE_W-1:0]  line_bytes_ff, line_bytes_in;
   logic [BYTE_W-1:0]  held_char_ff, held_char_in;
   logic               held_valid_ff, held_valid_in;
   logic [BYTE_W-1:0]  first_char_ff, first_char_in;
   logic [NUM_W-1:0]   acc_ff, acc_in;
   num_flags_type      flags_ff, flags_in;
   logic [CNT_W-1:0]   args_left_ff, args_left_in;
   logic [IDX_W-1:0]   pushed_ff, pushed_in;
   logic [CNT_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [1:0]         skip_left_ff, skip_left_in;
   logic [CNT_W-1:0]   cmd_count_ff, cmd_count_in;

   logic [NUM_W-1:0]   num_acc;
   num_flags_type      num_flags;

   logic               is_nl;
   logic [BYTE_W-1:0]  first_eff;
   logic               num_ok;
   logic               num_zero;
   logic               num_neg;
   logic               num_minus_one;
   logic               num_below;
   logic               line_full;
   logic [LINE_W-1:0]  line_bytes_inc;
   logic               hdr_bad_prefix;
   logic               hdr_bad_num;
   logic               hdr_empty;
   logic               arg_bad_prefix;
   logic               arg_bad_num;
   logic               arg_null;
   logic               args_last;
   logic [CNT_W-1:0]   args_dec;
   logic               skip_end;
   logic [IDX_W-1:0]   idx_data;

   rcp_num u_num (
      .ch        (held_char_ff),
      .first     (line_bytes_ff == 17'd2),
      .acc_cur   (acc_ff),
      .flags_cur (flags_ff),
      .acc_nxt   (num_acc),
      .flags_nxt (num_flags)
   );

   assign is_nl          = (in_byte == CH_NL);
   assign first_eff      = (line_bytes_ff == '0) ? CH_NL : first_char_ff;
   assign num_ok         = flags_ff.digit && !flags_ff.ovf;
   assign num_zero       = (acc_ff == '0);
   assign num_neg        = flags_ff.sign && !num_zero;
   assign num_minus_one  = flags_ff.sign && (acc_ff == 32'd1);
   assign num_below      = flags_ff.sign && (acc_ff > 32'd1);
   assign line_bytes_inc = line_bytes_ff + 17'd1;
   assign line_full      = (line_bytes_inc >= line_limit);
   assign hdr_bad_prefix = (first_eff != CH_STAR);
   assign hdr_bad_num    = !hdr_bad_prefix && !num_ok;
   assign hdr_empty      = !hdr_bad_prefix && num_ok && (num_neg || num_zero);
   assign arg_bad_prefix = (line_bytes_ff < MIN_ARG_LINE) || (first_eff != CH_DOLLAR);
   assign arg_bad_num    = !arg_bad_prefix && (!num_ok || num_below);
   assign arg_null       = !arg_bad_prefix && !arg_bad_num && num_minus_one;
   assign args_last      = (args_left_ff <= 31'd1);
   assign args_dec       = (args_left_ff != '0) ? args_left_ff - 31'd1 : args_left_ff;
   assign skip_end       = (skip_left_ff <= 2'd1);
   assign idx_data       = (pushed_ff != '0 && pushed_ff < IDX_MAX) ?
                           pushed_ff - IDX_W'(1) : pushed_ff;

   // next state
   always_comb begin
      logic drop;
      logic hdr_ok;
      logic clr_line;
      logic arg_done;
      drop          = 1'b0;
      hdr_ok        = 1'b0;
      clr_line      = 1'b0;
      arg_done      = 1'b0;
      phase_in      = phase_ff;
      line_bytes_in = line_bytes_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      first_char_in = first_char_ff;
      acc_in        = acc_ff;
      flags_in      = flags_ff;
      args_left_in  = args_left_ff;
      pushed_in     = pushed_ff;
      bytes_left_in = bytes_left_ff;
      skip_left_in  = skip_left_ff;
      cmd_count_in  = cmd_count_ff;
      unique case (phase_ff)
         PH_HDR: begin
            if (is_nl) begin
               if (hdr_bad_prefix || hdr_bad_num || hdr_empty) begin
                  drop     = 1'b1;
                  phase_in = PH_HDR;
               end else begin
                  hdr_ok   = 1'b1;
                  phase_in = PH_ARGHDR;
               end
            end
         end
         PH_ARGHDR: begin
            if (is_nl) begin
               if (arg_bad_prefix || arg_bad_num) begin
                  drop     = 1'b1;
                  phase_in = PH_HDR;
               end else if (arg_null) begin
                  arg_done = 1'b1;
               end else begin
                  clr_line = 1'b1;
                  if (pushed_ff < IDX_MAX) begin
                     pushed_in = pushed_ff + IDX_W'(1);
                  end
                  if (num_zero) begin
                     skip_left_in = SKIP_BYTES;
                     phase_in     = PH_SKIP;
                  end else begin
                     bytes_left_in = acc_ff[CNT_W-1:0];
                     phase_in      = PH_DATA;
                  end
               end
            end
         end
         PH_DATA: begin
            if (bytes_left_ff != '0) begin
               bytes_left_in = bytes_left_ff - 31'd1;
            end
            if (bytes_left_ff <= 31'd1) begin
               skip_left_in = SKIP_BYTES;
               phase_in     = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (!skip_end) begin
               skip_left_in = skip_left_ff - 2'd1;
            end else begin
               skip_left_in = '0;
               arg_done     = 1'b1;
            end
         end
         PH_DISCARD: begin
            if (is_nl) begin
               drop     = 1'b1;
               phase_in = PH_HDR;
            end
         end
         default: begin
            drop     = 1'b1;
            phase_in = PH_HDR;
         end
      endcase

      // header byte that is not a line end
      if ((phase_ff == PH_HDR || phase_ff == PH_ARGHDR) && !is_nl) begin
         if (line_bytes_ff == '0) begin
            first_char_in = in_byte;
         end else begin
            if (held_valid_ff) begin
               acc_in   = num_acc;
               flags_in = num_flags;
            end
            held_char_in  = in_byte;
            held_valid_in = 1'b1;
         end
         line_bytes_in = line_bytes_inc;
         if (line_full) begin
            drop     = 1'b1;
            phase_in = PH_DISCARD;
         end
      end

      if (arg_done) begin
         if (args_last) begin
            drop     = 1'b1;
            phase_in = PH_HDR;
         end else begin
            args_left_in = args_dec;
            clr_line     = 1'b1;
            phase_in     = PH_ARGHDR;
         end
      end

      if (drop || hdr_ok) begin
         clr_line      = 1'b1;
         args_left_in  = '0;
         pushed_in     = '0;
         bytes_left_in = '0;
         skip_left_in  = '0;
         cmd_count_in  = '0;
      end
      if (hdr_ok) begin
         args_left_in = acc_ff[CNT_W-1:0];
         cmd_count_in = acc_ff[CNT_W-1:0];
      end
      if (clr_line) begin
         line_bytes_in = '0;
         held_char_in  = '0;
         held_valid_in = 1'b0;
         first_char_in = '0;
         acc_in        = '0;
         flags_in      = '0;
      end
   end

   // result word
   always_comb begin
      rsp_fire = 1'b0;
      rsp      = '0;
      unique case (phase_ff)
         PH_HDR: begin
            if (is_nl) begin
               if (hdr_bad_prefix) begin
                  rsp_fire      = 1'b1;
                  rsp.event_res = EV_PREFIX;
               end else if (hdr_bad_num) begin
                  rsp_fire      = 1'b1;
                  rsp.event_res = EV_NUMBER;
               end else if (hdr_empty) begin
                  rsp_fire      = 1'b1;
                  rsp.event_res = EV_CMD_DONE;
               end
            end else if (line_full) begin
               rsp_fire      = 1'b1;
               rsp.event_res = EV_LONG;
            end
         end
         PH_ARGHDR: begin
            if (is_nl) begin
               rsp_fire = 1'b1;
               if (arg_bad_prefix) begin
                  rsp.event_res = EV_PREFIX;
               end else if (arg_bad_num) begin
                  rsp.event_res = EV_NUMBER;
               end else if (arg_null) begin
                  rsp_fire       = args_last;
                  rsp.event_res  = EV_CMD_DONE;
                  rsp.arg_length = cmd_count_ff;
               end else begin
                  rsp.event_res  = EV_ARG_START;
                  rsp.arg_index  = AIDX_W'(pushed_ff);
                  rsp.arg_length = acc_ff[CNT_W-1:0];
               end
            end else if (line_full) begin
               rsp_fire      = 1'b1;
               rsp.event_res = EV_LONG;
            end
         end
         PH_DATA: begin
            rsp_fire        = 1'b1;
            rsp.event_res   = EV_ARG_BYTE;
            rsp.arg_index   = AIDX_W'(idx_data);
            rsp.data_byte   = in_byte;
            rsp.last_of_arg = (bytes_left_ff <= 31'd1);
         end
         PH_SKIP: begin
            if (skip_end && args_last) begin
               rsp_fire       = 1'b1;
               rsp.event_res  = EV_CMD_DONE;
               rsp.arg_length = cmd_count_ff;
            end
         end
         default: begin
            rsp_fire = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR;
         line_bytes_ff <= '0;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         first_char_ff <= '0;
         acc_ff        <= '0;
         flags_ff      <= '0;
         args_left_ff  <= '0;
         pushed_ff     <= '0;
         bytes_left_ff <= '0;
         skip_left_ff  <= '0;
         cmd_count_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         line_bytes_ff <= line_bytes_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         first_char_ff <= first_char_in;
         acc_ff        <= acc_in;
         flags_ff      <= flags_in;
         args_left_ff  <= args_left_in;
         pushed_ff     <= pushed_in;
         bytes_left_ff <= bytes_left_in;
         skip_left_ff  <= skip_left_in;
         cmd_count_ff  <= cmd_count_in;
      end
   end

endmodule

// ===== sv/rcp_checker.sv =====
// ----------------------------------------------------------------------------
// rcp_checker
// Port-level checks for the request command parser, bound to the top level.
// ----------------------------------------------------------------------------
module rcp_checker
   import rcp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [EV_W-1:0]   rsp_event_res,
   input  logic [AIDX_W-1:0] rsp_arg_index,
   input  logic [CNT_W-1:0]  rsp_arg_length,
   input  logic [BYTE_W-1:0] rsp_data_byte,
   input  logic              rsp_last_of_arg
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_arg_index) && $stable(rsp_arg_length)
         && $stable(rsp_data_byte) && $stable(rsp_last_of_arg))
      else $error("stalled result word changed");

   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_ARG_BYTE |-> rsp_data_byte == '0
         && !rsp_last_of_arg)
      else $error("data fields set on a non-data word");

   a_len_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_ARG_BYTE || rsp_event_res == EV_PREFIX
         || rsp_event_res == EV_NUMBER || rsp_event_res == EV_LONG)
         |-> rsp_arg_length == '0)
      else $error("length set on a word that carries none");

   a_index_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_ARG_BYTE && rsp_event_res != EV_ARG_START
         |-> rsp_arg_index == '0)
      else $error("index set on a word that carries none");

endmodule

bind resp_command_parser_top rcp_checker u_rcp_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks resp_command_parser_top against a cycle-free model of the parser.
// Request bytes go in over a valid/ready channel with random gaps. Each taken
// byte is run through the model, and any word it yields is queued. Every word
// the block returns is compared field by field with the oldest queued one.
// Tests cover good and broken commands, number limits, the line limit, a
// long result stall and a random byte stream.
// ----------------------------------------------------------------------------
module testbench;
   import rcp_pkg::*;

   localparam int MAX_ARGS      = 1024;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 4000;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_in_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [EV_W-1:0]   rsp_event_res;
   logic [AIDX_W-1:0] rsp_arg_index;
   logic [CNT_W-1:0]  rsp_arg_length;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic              rsp_last_of_arg;
   logic              csr_wr_en = 1'b0;
   logic [LINE_W-1:0] csr_wr_data = '0;

   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   logic        holding = 1'b0;
   event        hold_go;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;

   rsp_type           expected_q[$];
   logic [BYTE_W-1:0] stream_q[$];

   // parser model state
   logic [LINE_W-1:0] line_limit_q = LINE_LIMIT_RESET;
   phase_type         parse_phase = PH_HDR;
   int unsigned       line_len = 0;
   logic [BYTE_W-1:0] held_byte = '0;
   bit                held_ok = 1'b0;
   logic [BYTE_W-1:0] lead_byte = '0;
   logic [NUM_W-1:0]  num_acc = '0;
   num_flags_type     num_fl = '0;
   logic [31:0]       args_left = '0;
   logic [31:0]       bytes_left = '0;
   logic [31:0]       cmd_count = '0;
   int unsigned       args_pushed = 0;
   int unsigned       skip_left = 0;

   resp_command_parser_top #(
      .MAX_ARGS(MAX_ARGS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_arg_index  (rsp_arg_index),
      .rsp_arg_length (rsp_arg_length),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last_of_arg(rsp_last_of_arg),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic void clear_line();
      line_len = 0;
      held_byte = '0;
      held_ok = 1'b0;
      lead_byte = '0;
      num_acc = '0;
      num_fl = '0;
   endfunction

   function automatic void drop_cmd(phase_type nxt);
      clear_line();
      args_left = '0;
      args_pushed = 0;
      bytes_left = '0;
      skip_left = 0;
      cmd_count = '0;
      parse_phase = nxt;
   endfunction

   function automatic rsp_type make_word(logic [EV_W-1:0] ev, int unsigned idx,
                                         logic [31:0] len, logic [BYTE_W-1:0] data,
                                         bit last);
      rsp_type w;
      w.event_res   = ev;
      w.arg_index   = AIDX_W'(idx);
      w.arg_length  = len[CNT_W-1:0];
      w.data_byte   = data;
      w.last_of_arg = last;
      return w;
   endfunction

   function automatic void feed_digit(logic [BYTE_W-1:0] c, bit first);
      logic [31:0] d;
      logic [31:0] lim;
      if (num_fl.stop) return;
      if (first && c == CH_MINUS) begin
         num_fl.sign = 1'b1;
         return;
      end
      if (c < CH_ZERO || c > CH_NINE) begin
         num_fl.stop = 1'b1;
         return;
      end
      num_fl.digit = 1'b1;
      if (num_fl.ovf) return;
      d = c - CH_ZERO;
      lim = num_fl.sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (num_acc > (lim - d) / 10) num_fl.ovf = 1'b1;
      else num_acc = num_acc * 10 + d;
   endfunction

   function automatic bit finish_arg(output rsp_type w);
      logic [31:0] n;
      if (args_left > 0) args_left--;
      if (args_left == 0) begin
         n = cmd_count;
         drop_cmd(PH_HDR);
         w = make_word(EV_CMD_DONE, 0, n, '0, 1'b0);
         return 1'b1;
      end
      clear_line();
      parse_phase = PH_ARGHDR;
      return 1'b0;
   endfunction

   function automatic bit close_line(output rsp_type w);
      logic [BYTE_W-1:0] first;
      longint            v;
      bit                ok;
      int unsigned       idx;
      first = (line_len == 0) ? CH_NL : lead_byte;
      ok = num_fl.digit && !num_fl.ovf;
      v = num_fl.sign ? -longint'({32'd0, num_acc}) : longint'({32'd0, num_acc});
      if (parse_phase == PH_HDR) begin
         if (first != CH_STAR) begin
            drop_cmd(PH_HDR);
            w = make_word(EV_PREFIX, 0, '0, '0, 1'b0);
            return 1'b1;
         end
         if (!ok) begin
            drop_cmd(PH_HDR);
            w = make_word(EV_NUMBER, 0, '0, '0, 1'b0);
            return 1'b1;
         end
         if (v <= 0) begin
            drop_cmd(PH_HDR);
            w = make_word(EV_CMD_DONE, 0, '0, '0, 1'b0);
            return 1'b1;
         end
         drop_cmd(PH_ARGHDR);
         args_left = v[31:0];
         cmd_count = v[31:0];
         return 1'b0;
      end
      if (line_len < MIN_ARG_LINE || first != CH_DOLLAR) begin
         drop_cmd(PH_HDR);
         w = make_word(EV_PREFIX, 0, '0, '0, 1'b0);
         return 1'b1;
      end
      if (!ok || v < -1) begin
         drop_cmd(PH_HDR);
         w = make_word(EV_NUMBER, 0, '0, '0, 1'b0);
         return 1'b1;
      end
      if (v == -1) return finish_arg(w);
      idx = args_pushed;
      if (args_pushed < MAX_ARGS - 1) args_pushed++;
      clear_line();
      if (v == 0) begin
         skip_left = SKIP_BYTES;
         parse_phase = PH_SKIP;
      end else begin
         bytes_left = v[31:0];
         parse_phase = PH_DATA;
      end
      w = make_word(EV_ARG_START, idx, v[31:0], '0, 1'b0);
      return 1'b1;
   endfunction

   function automatic bit parse_byte(logic [BYTE_W-1:0] b, output rsp_type w);
      int unsigned idx;
      bit          last;
      case (parse_phase)
         PH_HDR, PH_ARGHDR: begin
            if (b == CH_NL) return close_line(w);
            if (line_len == 0) begin
               lead_byte = b;
            end else begin
               if (held_ok) feed_digit(held_byte, line_len == 2);
               held_byte = b;
               held_ok = 1'b1;
            end
            line_len++;
            if (line_len >= line_limit_q) begin
               drop_cmd(PH_DISCARD);
               w = make_word(EV_LONG, 0, '0, '0, 1'b0);
               return 1'b1;
            end
            return 1'b0;
         end
         PH_DATA: begin
            idx = (args_pushed > 0 && args_pushed < MAX_ARGS - 1) ? args_pushed - 1
                                                                 : args_pushed;
            last = (bytes_left <= 1);
            if (bytes_left > 0) bytes_left--;
            if (bytes_left == 0) begin
               skip_left = SKIP_BYTES;
               parse_phase = PH_SKIP;
            end
            w = make_word(EV_ARG_BYTE, idx, '0, b, last);
            return 1'b1;
         end
         PH_SKIP: begin
            if (skip_left > 1) begin
               skip_left--;
               return 1'b0;
            end
            skip_left = 0;
            return finish_arg(w);
         end
         PH_DISCARD: begin
            if (b == CH_NL) drop_cmd(PH_HDR);
            return 1'b0;
         end
         default: begin
            drop_cmd(PH_HDR);
            return 1'b0;
         end
      endcase
   endfunction

   // -------------------------------------------------------- stream building

   function automatic void add_byte(logic [BYTE_W-1:0] b);
      stream_q.insert(stream_q.size(), b);
   endfunction

   function automatic void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_line(string s);
      add_text(s);
      add_byte(CH_CR);
      add_byte(CH_NL);
   endfunction

   // long junk line: brings the parser back to the array header unless it sits
   // deep inside a payload
   function automatic void add_resync();
      repeat (63) add_byte("x");
      add_byte(CH_NL);
   endfunction

   function automatic void add_number_line(logic [BYTE_W-1:0] prefix, longint v);
      add_byte(prefix);
      if ($urandom_range(9) == 0) add_text("00");
      add_text($sformatf("%0d", v));
      if ($urandom_range(19) == 0) add_byte("z");
      if ($urandom_range(19) == 0) add_byte(CH_NL);
      else add_line("");
   endfunction

   function automatic void add_random_command();
      int          kind;
      int          count;
      int          len;
      int          i;
      int unsigned start;
      int unsigned pos;
      logic [BYTE_W-1:0] b;
      kind = $urandom_range(99);
      start = stream_q.size();
      if (kind < 80) begin
         count = $urandom_range(1, 4);
         add_number_line(CH_STAR, longint'(count));
         for (i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) begin
               add_number_line(CH_DOLLAR, -1);
            end else begin
               len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
               add_number_line(CH_DOLLAR, longint'(len));
               repeat (len) add_byte(BYTE_W'($urandom_range(255)));
               if ($urandom_range(9) == 0) repeat (2) add_byte(BYTE_W'($urandom_range(255)));
               else add_line("");
            end
         end
         pos = $urandom_range(start, stream_q.size() - 1);
         if (kind >= 72 && kind < 76) begin
            stream_q[pos] = BYTE_W'($urandom_range(255));
         end else if (kind >= 76) begin
            while (stream_q.size() > pos) void'(stream_q.pop_back());
         end
      end else if (kind < 85) begin
         case ($urandom_range(2))
            0: add_number_line(CH_STAR, 0);
            1: add_number_line(CH_STAR, -longint'($urandom_range(1, 99)));
            default: add_line("*-2147483648");
         endcase
      end else if (kind < 91) begin
         case ($urandom_range(5))
            0: add_number_line(CH_STAR, 64'sd2147483647 + $urandom_range(0, 3));
            1: add_line("*-2147483649");
            2: add_line("*99999999999");
            3: begin
               add_line("*1");
               add_number_line(CH_DOLLAR, -2 - longint'($urandom_range(0, 100)));
            end
            4: begin
               add_line("*1");
               add_line("$-2147483648");
            end
            default: begin
               if ($urandom_range(1)) add_line("*-");
               else add_line("$");
            end
         endcase
      end else if (kind < 96) begin
         repeat ($urandom_range(1, 6)) begin
            b = BYTE_W'($urandom_range(255));
            if (b == CH_NL || b == CH_DOLLAR) b = "#";
            add_byte(b);
         end
         add_byte(CH_NL);
      end else begin
         add_byte($urandom_range(1) ? CH_STAR : CH_DOLLAR);
         repeat ($urandom_range(3, 14)) add_byte(CH_ZERO + BYTE_W'($urandom_range(9)));
         add_line("");
      end
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_byte(logic [BYTE_W-1:0] b);
      rsp_type w;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (parse_byte(b, w)) expected_q.insert(expected_q.size(), w);
   endtask

   task automatic send_stream();
      while (stream_q.size() > 0) send_byte(stream_q.pop_front());
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_line_limit(logic [LINE_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      line_limit_q = v;
   endtask

   always @(posedge clock) begin
      rsp_ready <= !holding && ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      forever begin
         @(hold_go);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- checking

   function automatic string word_text(rsp_type w);
      return $sformatf("ev=%0d idx=%0d len=%0d data=0x%02h last=%0b", w.event_res,
                       w.arg_index, w.arg_length, w.data_byte, w.last_of_arg);
   endfunction

   function automatic void log_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_event_res, rsp_arg_index, rsp_arg_length, rsp_data_byte,
                rsp_last_of_arg};
         if (expected_q.size() == 0) begin
            log_mismatch({"unexpected word: ", word_text(got)});
         end else begin
            want = expected_q.pop_front();
            if (got.event_res !== want.event_res || got.arg_index !== want.arg_index ||
                got.arg_length !== want.arg_length || got.data_byte !== want.data_byte ||
                got.last_of_arg !== want.last_of_arg)
               log_mismatch({"mismatch: expected ", word_text(want), ", got ",
                             word_text(got)});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("[resp_command_parser_top] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed_commands();
      add_line("*1");
      add_line("$3");
      add_line("GET");
      // null, empty and binary arguments, odd trailer on the last one
      add_line("*4");
      add_line("$-1");
      add_line("$0");
      add_line("");
      add_line("$2");
      add_byte(8'hFF);
      add_byte(8'h00);
      add_line("");
      add_line("$1");
      add_text("zQ!");
      add_line("*0");
      add_line("*-7");
      add_line("*-2147483648");
      add_line("+OK");
      add_byte(CH_NL);
      add_line("*1");
      add_line("$");
      add_line("*1");
      add_line("#3");
      add_line("*x");
      add_line("*-");
      add_line("*2147483648");
      add_line("*-2147483649");
      add_line("*1");
      add_line("$-2");
      add_line("*1");
      add_line("$-2147483648");
      add_line("*2147483647");
      add_byte(CH_NL);
      // bare LF: the only digit falls in the dropped tail
      add_text("*1");
      add_byte(CH_NL);
      add_line("*1x");
      add_line("$01");
      add_byte(8'h80);
      add_text("ab");
      send_stream();
   endtask

   task automatic test_line_limit();
      settle();
      add_resync();
      send_stream();
      settle();
      set_line_limit(LINE_W'(4));
      add_line("*1");
      add_line("$1");
      add_line("A");
      add_line("*10");
      add_line("*1");
      add_line("$10");
      send_stream();
      settle();
      set_line_limit(LINE_W'(5));
      add_line("*2");
      add_line("$-1");
      add_line("$1");
      add_line("b");
      add_line("*123");
      send_stream();
   endtask

   task automatic test_random_stream(int n, logic [LINE_W-1:0] lim);
      settle();
      set_line_limit(lim);
      while (stream_q.size() < n) add_random_command();
      send_stream();
   endtask

   task automatic test_stall_fill();
      settle();
      add_resync();
      send_stream();
      settle();
      -> hold_go;
      add_line("*2");
      add_line("$60");
      repeat (60) add_byte(BYTE_W'($urandom_range(255)));
      add_line("");
      add_line("$-1");
      send_stream();
   endtask

   // leaves the parser inside a huge argument, so it runs last
   task automatic test_length_extreme();
      settle();
      add_resync();
      add_line("*1");
      add_line("$2147483647");
      repeat (24) add_byte(BYTE_W'($urandom_range(255)));
      send_stream();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct = 37;
      rsp_stall_pct = 63;
      test_directed_commands();
      test_line_limit();
      test_random_stream(110, LINE_LIMIT_RESET);
      test_random_stream(90, LINE_W'($urandom_range(4, 12)));

      req_gap_pct = 63;
      rsp_stall_pct = 37;
      test_random_stream(110, 17'h10000);
      test_stall_fill();
      test_random_stream(70, LINE_W'(5));

      req_gap_pct = 0;
      rsp_stall_pct = 0;
      test_random_stream(110, LINE_W'($urandom_range(13, 64)));
      test_length_extreme();
      settle();

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("[resp_command_parser_top] OK");
      end else begin
         $display("[resp_command_parser_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rcp_pkg.sv
sv/rcp_num.sv
sv/rcp_fsm.sv
sv/resp_command_parser_top.sv
sv/rcp_checker.sv
tb/testbench.sv
